// ----- rtl/tlvv_pkg.sv -----
// Shared types and constants for the TLV stream validator.
package tlvv_pkg;

	// Parser phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_VALUE  = 2'd1,
		PH_DRAIN  = 2'd2
	} phase_t;

	// Status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_TRUNC = 3'd1;
	localparam logic [2:0] ST_ZERO  = 3'd2;
	localparam logic [2:0] ST_LONG  = 3'd3;
	localparam logic [2:0] ST_DUP   = 3'd4;
	localparam logic [2:0] ST_FULL  = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] CFG_MAX_LEN   = 3'd0;
	localparam logic [2:0] CFG_TAG_COUNT = 3'd1;
	localparam logic [2:0] CFG_TAG_A     = 3'd2;
	localparam logic [2:0] CFG_TAG_B     = 3'd3;
	localparam logic [2:0] CFG_TAG_C     = 3'd4;
	localparam logic [2:0] CFG_TAG_D     = 3'd5;

	localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

	// Last header byte index
	localparam logic [2:0] HDR_LAST = 3'd7;

	// Output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;
	localparam int OQ_CW    = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] elem_tag;
		logic [7:0]  value_byte;
		logic [31:0] value_index;
		logic        element_last;
		logic [2:0]  status;
		logic [4:0]  element_count;
		logic        invalid_tag;
		logic        run_last;
	} out_item_t;

	// Queue write request: one or two results per transaction
	typedef struct packed {
		logic first;
		logic second;
	} q_push_t;

endpackage

// ----- rtl/tlvv_cell.sv -----
// One cell of the seen-tag chain: holds a tag, passes it on, compares it.
module tlvv_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift_en,
	input  logic [31:0] tag_in,
	input  logic [31:0] probe,
	input  logic        live,
	output logic [31:0] tag_out,
	output logic        hit
);

	logic [31:0] tag_q;
	logic        hit_s1;

	// Advance the stored tag from the neighbor
	always_ff @(posedge clk) begin
		if (shift_en) begin
			tag_q <= tag_in;
		end
	end

	// Compare against the tag under test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= live && (tag_q == probe);
		end
	end

	assign tag_out = tag_q;
	assign hit     = hit_s1;

endmodule

// ----- rtl/tlvv_out_queue.sv -----
// Small result queue that takes up to two results per transaction.
module tlvv_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tlvv_pkg::q_push_t   push,
	input  tlvv_pkg::out_item_t item0,
	input  tlvv_pkg::out_item_t item1,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output tlvv_pkg::out_item_t out_item
);

	tlvv_pkg::out_item_t            entry_q [tlvv_pkg::OQ_DEPTH];
	logic [tlvv_pkg::OQ_AW-1:0]     wr_ptr_q;
	logic [tlvv_pkg::OQ_AW-1:0]     rd_ptr_q;
	logic [tlvv_pkg::OQ_CW-1:0]     cnt_q;
	logic [tlvv_pkg::OQ_CW-1:0]     n_push;
	logic                           pop;
	logic [tlvv_pkg::OQ_AW-1:0]     wr_ptr_p1;

	assign pop       = out_valid && out_ready;
	assign n_push    = tlvv_pkg::OQ_CW'(push.first) + tlvv_pkg::OQ_CW'(push.second);
	assign wr_ptr_p1 = wr_ptr_q + tlvv_pkg::OQ_AW'(1);

	// Write incoming results at the tail
	always_ff @(posedge clk) begin
		for (int i = 0; i < tlvv_pkg::OQ_DEPTH; i++) begin
			if (push.first && wr_ptr_q == tlvv_pkg::OQ_AW'(i)) begin
				entry_q[i] <= item0;
			end else if (push.second && wr_ptr_p1 == tlvv_pkg::OQ_AW'(i)) begin
				entry_q[i] <= item1;
			end
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[tlvv_pkg::OQ_AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tlvv_pkg::OQ_AW'(1);
			end
			cnt_q <= cnt_q + n_push - tlvv_pkg::OQ_CW'(pop);
		end
	end

	assign room      = cnt_q <= tlvv_pkg::OQ_CW'(tlvv_pkg::OQ_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_item  = entry_q[rd_ptr_q];

endmodule

// ----- rtl/tlv_stream_validator.sv -----
// Top level of the TLV stream validator: byte parser, tag cell chain, result queue.
// Takes one byte per cycle while the result queue has room; results are registered in that queue.
// A byte that closes the buffer inside a value yields two results, value then status, queued together.
// The duplicate-tag check runs through the cell chain during the four length bytes,
// a compare stage in each cell and one OR stage, so it is ready when the header completes.
// Reset clears the parser, counts, flags, queue and registers; cell tags are not cleared.
module tlv_stream_validator #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tlvv_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tlvv_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	// Configuration registers
	logic [31:0] max_len_q;
	logic [2:0]  tag_cnt_q;
	logic [31:0] vtag_a_q;
	logic [31:0] vtag_b_q;
	logic [31:0] vtag_c_q;
	logic [31:0] vtag_d_q;

	// Parser state
	tlvv_pkg::phase_t phase_q, phase_n;
	logic [2:0]       hbc_q, hbc_n;
	logic [31:0]      tag_q, tag_n;
	logic [31:0]      len_q, len_n;
	logic [31:0]      pos_q, pos_n;
	logic [CW-1:0]    cnt_q, cnt_n;
	logic [2:0]       err_q, err_n;
	logic             bad_q, bad_n;
	logic             dup_s2;

	logic             accept;
	logic [7:0]       b;
	logic             buf_end;
	logic [31:0]      full_len;
	logic [2:0]       hdr_st;
	logic             seen_full;
	logic             allowed;
	logic [2:0]       tag_lim;
	logic             elem_done;
	logic             shift_en;
	logic             in_value;
	logic [2:0]       end_st;
	logic [8:0]       cnt_wide;
	logic             room;

	tlvv_pkg::q_push_t   push;
	tlvv_pkg::out_item_t val_item, sts_item, item0;

	logic [31:0]             chain [MAX_ELEMENTS+1];
	logic [MAX_ELEMENTS-1:0] hits;
	logic [MAX_ELEMENTS-1:0] live;

	assign accept  = in_valid && in_ready;
	assign in_ready = room;
	assign b       = in_item.data_byte;
	assign buf_end = in_item.buffer_end;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= tlvv_pkg::MAX_LEN_RESET;
			tag_cnt_q <= '0;
			vtag_a_q  <= '0;
			vtag_b_q  <= '0;
			vtag_c_q  <= '0;
			vtag_d_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tlvv_pkg::CFG_MAX_LEN:   max_len_q <= cfg_data;
				tlvv_pkg::CFG_TAG_COUNT: tag_cnt_q <= cfg_data[2:0];
				tlvv_pkg::CFG_TAG_A:     vtag_a_q  <= cfg_data;
				tlvv_pkg::CFG_TAG_B:     vtag_b_q  <= cfg_data;
				tlvv_pkg::CFG_TAG_C:     vtag_c_q  <= cfg_data;
				tlvv_pkg::CFG_TAG_D:     vtag_d_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Seen-tag chain: newest tag enters cell 0, live cells are those below the count
	assign chain[0] = tag_q;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		assign live[i] = cnt_q > CW'(i);
		tlvv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.tag_in   (chain[i]),
			.probe    (tag_q),
			.live     (live[i]),
			.tag_out  (chain[i+1]),
			.hit      (hits[i])
		);
	end

	// Combine cell hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_s2 <= 1'b0;
		end else begin
			dup_s2 <= |hits;
		end
	end

	// Header checks on the last length byte
	assign full_len  = {b, len_q[23:0]};
	assign seen_full = cnt_q >= CW'(MAX_ELEMENTS);
	assign tag_lim   = (tag_cnt_q > 3'd4) ? 3'd4 : tag_cnt_q;
	assign allowed   = (tag_lim == 3'd0)
		|| (tag_lim >= 3'd1 && tag_q == vtag_a_q)
		|| (tag_lim >= 3'd2 && tag_q == vtag_b_q)
		|| (tag_lim >= 3'd3 && tag_q == vtag_c_q)
		|| (tag_lim >= 3'd4 && tag_q == vtag_d_q);

	always_comb begin
		if (full_len == '0) begin
			hdr_st = tlvv_pkg::ST_ZERO;
		end else if (full_len > max_len_q) begin
			hdr_st = tlvv_pkg::ST_LONG;
		end else if (dup_s2) begin
			hdr_st = tlvv_pkg::ST_DUP;
		end else if (seen_full) begin
			hdr_st = tlvv_pkg::ST_FULL;
		end else begin
			hdr_st = tlvv_pkg::ST_OK;
		end
	end

	assign elem_done = ({1'b0, pos_q} + 33'd1) >= {1'b0, len_q};

	// Next state and results
	always_comb begin
		phase_n  = phase_q;
		hbc_n    = hbc_q;
		tag_n    = tag_q;
		len_n    = len_q;
		pos_n    = pos_q;
		cnt_n    = cnt_q;
		err_n    = err_q;
		bad_n    = bad_q;
		shift_en = 1'b0;
		in_value = 1'b0;
		end_st   = tlvv_pkg::ST_OK;
		cnt_wide = '0;

		if (accept) begin
			case (phase_q)
				tlvv_pkg::PH_HEADER: begin
					if (!hbc_q[2]) begin
						tag_n[{hbc_q[1:0], 3'b000} +: 8] = b;
					end else begin
						len_n[{hbc_q[1:0], 3'b000} +: 8] = b;
					end
					if (hbc_q == tlvv_pkg::HDR_LAST) begin
						hbc_n = '0;
						if (hdr_st == tlvv_pkg::ST_OK) begin
							shift_en = 1'b1;
							cnt_n    = cnt_q + CW'(1);
							bad_n    = bad_q | ~allowed;
							phase_n  = tlvv_pkg::PH_VALUE;
							pos_n    = '0;
						end else begin
							err_n   = hdr_st;
							phase_n = tlvv_pkg::PH_DRAIN;
						end
					end else begin
						hbc_n = hbc_q + 3'd1;
					end
				end
				tlvv_pkg::PH_VALUE: begin
					in_value = 1'b1;
					if (elem_done) begin
						phase_n = tlvv_pkg::PH_HEADER;
						hbc_n   = '0;
						tag_n   = '0;
						len_n   = '0;
						pos_n   = '0;
					end else begin
						pos_n = pos_q + 32'd1;
					end
				end
				default: ;
			endcase

			// Close the buffer: report, then restart
			if (buf_end) begin
				end_st = err_n;
				if (end_st == tlvv_pkg::ST_OK
					&& (phase_n != tlvv_pkg::PH_HEADER || hbc_n != '0)) begin
					end_st = tlvv_pkg::ST_TRUNC;
				end
				cnt_wide = 9'(cnt_n);
				phase_n  = tlvv_pkg::PH_HEADER;
				hbc_n    = '0;
				tag_n    = '0;
				len_n    = '0;
				pos_n    = '0;
				cnt_n    = '0;
				err_n    = tlvv_pkg::ST_OK;
				bad_n    = 1'b0;
			end
		end
	end

	// Build result items
	always_comb begin
		val_item              = '0;
		val_item.kind         = 1'b0;
		val_item.elem_tag     = tag_q;
		val_item.value_byte   = b;
		val_item.value_index  = pos_q;
		val_item.element_last = elem_done;
		val_item.run_last     = ~buf_end;

		sts_item               = '0;
		sts_item.kind          = 1'b1;
		sts_item.status        = end_st;
		sts_item.element_count = (end_st == tlvv_pkg::ST_OK) ? cnt_wide[4:0] : 5'd0;
		sts_item.invalid_tag   = (end_st == tlvv_pkg::ST_OK) ? bad_q | (shift_en & ~allowed)
			: 1'b0;
		sts_item.run_last      = 1'b1;

		item0       = in_value ? val_item : sts_item;
		push.first  = accept && (in_value || buf_end);
		push.second = accept && in_value && buf_end;
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlvv_pkg::PH_HEADER;
			hbc_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			err_q   <= tlvv_pkg::ST_OK;
			bad_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			hbc_q   <= hbc_n;
			tag_q   <= tag_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			cnt_q   <= cnt_n;
			err_q   <= err_n;
			bad_q   <= bad_n;
		end
	end

	tlvv_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item0     (item0),
		.item1     (sts_item),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- sim/tlvv_check.sv -----
// Checker for the TLV stream validator: follows register writes, predicts results, compares them.
`timescale 1ns / 100ps
module tlvv_check #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  tlvv_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  tlvv_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  mismatches,
	output int                  pending
);
	import tlvv_pkg::*;

	// Result kinds
	localparam logic KIND_VALUE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Stop printing after this many mismatches, keep counting
	localparam int PRINT_CAP = 200;

	// Register copy
	logic [31:0] max_len;
	logic [2:0]  tag_count;
	logic [31:0] allowed_tags [4];

	// Parser copy
	phase_t      phase;
	logic [2:0]  hdr_cnt;
	logic [31:0] tag_acc;
	logic [31:0] len_acc;
	logic [31:0] val_pos;
	logic [31:0] seen_tags [MAX_ELEMENTS];
	int          seen_cnt;
	logic [2:0]  err_code;
	logic        bad_tag;

	// Results owed by the block, oldest first
	out_item_t   results_due [$];
	out_item_t   oldest;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Start a new buffer
	task automatic restart_buffer();
		phase    = PH_HEADER;
		hdr_cnt  = '0;
		tag_acc  = '0;
		len_acc  = '0;
		val_pos  = '0;
		seen_cnt = 0;
		err_code = ST_OK;
		bad_tag  = 1'b0;
	endtask

	// Advance the parser by one byte and queue the results it owes
	task automatic parse_byte(input in_item_t it);
		out_item_t   r;
		logic [2:0]  verdict;
		logic [31:0] nxt;
		int          k;
		int          lim;
		bit          hit;
		r = '0;
		case (phase)
			PH_HEADER: begin
				k = int'(hdr_cnt);
				if (k < 4)
					tag_acc[8*k +: 8] = it.data_byte;
				else
					len_acc[8*(k-4) +: 8] = it.data_byte;
				if (hdr_cnt == HDR_LAST) begin
					// judge the header: zero, too long, duplicate, table full
					verdict = ST_OK;
					if (len_acc == '0)
						verdict = ST_ZERO;
					else if (len_acc > max_len)
						verdict = ST_LONG;
					else begin
						for (int i = 0; i < seen_cnt; i++)
							if (seen_tags[i] == tag_acc)
								verdict = ST_DUP;
						if (verdict == ST_OK && seen_cnt >= MAX_ELEMENTS)
							verdict = ST_FULL;
					end
					hdr_cnt = '0;
					if (verdict == ST_OK) begin
						seen_tags[seen_cnt] = tag_acc;
						seen_cnt++;
						// counts above four act as four
						lim = (tag_count > 3'd4) ? 4 : int'(tag_count);
						hit = (lim == 0);
						for (int i = 0; i < lim; i++)
							if (allowed_tags[i] == tag_acc)
								hit = 1'b1;
						if (!hit)
							bad_tag = 1'b1;
						phase   = PH_VALUE;
						val_pos = '0;
					end else begin
						err_code = verdict;
						phase    = PH_DRAIN;
					end
				end else begin
					hdr_cnt = hdr_cnt + 3'd1;
				end
			end
			PH_VALUE: begin
				nxt            = val_pos + 32'd1;
				r.kind         = KIND_VALUE;
				r.elem_tag     = tag_acc;
				r.value_byte   = it.data_byte;
				r.value_index  = val_pos;
				r.element_last = (nxt >= len_acc);
				r.run_last     = !it.buffer_end;
				results_due.push_back(r);
				if (r.element_last) begin
					phase   = PH_HEADER;
					hdr_cnt = '0;
					tag_acc = '0;
					len_acc = '0;
					val_pos = '0;
				end else begin
					val_pos = nxt;
				end
			end
			// drain: consume without results
			default: ;
		endcase

		// Close the buffer with its status
		if (it.buffer_end) begin
			r        = '0;
			r.kind   = KIND_STATUS;
			r.status = err_code;
			if (err_code == ST_OK && (phase != PH_HEADER || hdr_cnt != '0))
				r.status = ST_TRUNC;
			if (r.status == ST_OK) begin
				r.element_count = 5'(seen_cnt);
				r.invalid_tag   = bad_tag;
			end
			r.run_last = 1'b1;
			results_due.push_back(r);
			restart_buffer();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len   = MAX_LEN_RESET;
			tag_count = '0;
			foreach (allowed_tags[i])
				allowed_tags[i] = '0;
			restart_buffer();
			results_due.delete();
			pending = 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_LEN:   max_len = cfg_data;
					CFG_TAG_COUNT: tag_count = cfg_data[2:0];
					CFG_TAG_A:     allowed_tags[0] = cfg_data;
					CFG_TAG_B:     allowed_tags[1] = cfg_data;
					CFG_TAG_C:     allowed_tags[2] = cfg_data;
					CFG_TAG_D:     allowed_tags[3] = cfg_data;
					default: ;
				endcase
			end

			// Predict on each input transaction
			if (in_valid && in_ready)
				parse_byte(in_item);

			// Compare each output transaction with the oldest prediction
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					report("result with nothing expected, kind", 32'(out_item.kind), '0);
				end else begin
					oldest = results_due.pop_front();
					if (out_item.kind !== oldest.kind)
						report("kind", 32'(out_item.kind), 32'(oldest.kind));
					if (out_item.elem_tag !== oldest.elem_tag)
						report("elem_tag", out_item.elem_tag, oldest.elem_tag);
					if (out_item.value_byte !== oldest.value_byte)
						report("value_byte", 32'(out_item.value_byte),
							32'(oldest.value_byte));
					if (out_item.value_index !== oldest.value_index)
						report("value_index", out_item.value_index, oldest.value_index);
					if (out_item.element_last !== oldest.element_last)
						report("element_last", 32'(out_item.element_last),
							32'(oldest.element_last));
					if (out_item.status !== oldest.status)
						report("status", 32'(out_item.status), 32'(oldest.status));
					if (out_item.element_count !== oldest.element_count)
						report("element_count", 32'(out_item.element_count),
							32'(oldest.element_count));
					if (out_item.invalid_tag !== oldest.invalid_tag)
						report("invalid_tag", 32'(out_item.invalid_tag),
							32'(oldest.invalid_tag));
					if (out_item.run_last !== oldest.run_last)
						report("run_last", 32'(out_item.run_last), 32'(oldest.run_last));
				end
			end
			pending = results_due.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the TLV stream validator: clock, reset, register setup and byte stimulus.
`timescale 1ns / 100ps
module tb;
	import tlvv_pkg::*;

	localparam int MAX_EL        = 16;
	localparam int ITEM_BUDGET   = 1100;
	localparam int DIRECTED      = 27;
	localparam int PHASES        = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 1000000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int          mismatches;
	int          pending;
	int          cycle_count;
	int          bytes_sent;
	bit          hold_req;
	bit          tx_calm;

	// Register values as last written, for shaping the stimulus
	logic [31:0] cur_max;
	logic [31:0] cur_tags [4];

	// Buffer under construction and the tags it already uses
	in_item_t    frame_q [$];
	logic [31:0] used_tags [$];

	tlv_stream_validator #(
		.MAX_ELEMENTS(MAX_EL)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tlvv_check #(
		.MAX_ELEMENTS(MAX_EL)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Gap length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stalls, calm stretches, and a long hold-off on request
	initial begin
		int stall;
		int stretch;
		bit calm;
		stall     = 0;
		stretch   = 0;
		calm      = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				calm    = ($urandom_range(0, 3) == 0);
				stretch = $urandom_range(50, 200);
			end
			stretch--;
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
			end else begin
				stall = idle_len() - 1;
				out_ready <= 1'b0;
			end
		end
	end

	// Offer one byte and hold it until accepted; returns at a falling edge
	task automatic push_byte(input in_item_t it);
		int gap;
		gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic add_noise(input int n);
		for (int i = 0; i < n; i++)
			frame_q.push_back(in_item_t'{data_byte: 8'($urandom), buffer_end: 1'b0});
	endtask

	task automatic add_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			frame_q.push_back(in_item_t'{data_byte: w[8*i +: 8], buffer_end: 1'b0});
	endtask

	// Mark the last byte as buffer end and send the whole buffer
	task automatic send_frame();
		in_item_t last;
		if (frame_q.size() == 0)
			add_noise(1);
		last            = frame_q.pop_back();
		last.buffer_end = 1'b1;
		frame_q.push_back(last);
		tx_calm = ($urandom_range(0, 3) == 0);
		foreach (frame_q[i])
			push_byte(frame_q[i]);
		frame_q.delete();
		used_tags.delete();
	endtask

	// Wait for every owed result, then let the pipeline go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [31:0] mx, input logic [2:0] cnt,
			input logic [31:0] t0, input logic [31:0] t1,
			input logic [31:0] t2, input logic [31:0] t3);
		write_reg(CFG_MAX_LEN, mx);
		write_reg(CFG_TAG_COUNT, {29'd0, cnt});
		write_reg(CFG_TAG_A, t0);
		write_reg(CFG_TAG_B, t1);
		write_reg(CFG_TAG_C, t2);
		write_reg(CFG_TAG_D, t3);
		cfg_we   <= 1'b0;
		cur_max  = mx;
		cur_tags = '{t0, t1, t2, t3};
	endtask

	// Tag: a configured allowed-tag entry half the time, else random or an extreme
	function automatic logic [31:0] pick_tag();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			return cur_tags[$urandom_range(0, 3)];
		if (r == 2)
			return $urandom;
		return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
	endfunction

	// Length within the current maximum (1 to 4 when the maximum is zero), mostly short
	function automatic logic [31:0] pick_len();
		logic [31:0] hi;
		if (cur_max == '0)
			return $urandom_range(1, 4);
		hi = ($urandom_range(0, 9) == 0) ? 32'd24 : 32'd6;
		if (cur_max < hi)
			hi = cur_max;
		return $urandom_range(1, hi);
	endfunction

	// Append well-formed elements with distinct tags
	task automatic add_elements(input int n, input bit unit_len);
		logic [31:0] tag;
		logic [31:0] len;
		bit          dup;
		for (int k = 0; k < n; k++) begin
			do begin
				tag = pick_tag();
				dup = 1'b0;
				foreach (used_tags[j])
					if (used_tags[j] == tag)
						dup = 1'b1;
			end while (dup);
			used_tags.push_back(tag);
			len = unit_len ? 32'd1 : pick_len();
			add_word(tag);
			add_word(len);
			add_noise(int'(len));
		end
	endtask

	// One random buffer: mostly well-formed, the rest broken or noise
	task automatic random_frame();
		int          r;
		int          keep;
		logic [31:0] len;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			add_elements($urandom_range(1, 4), 1'b0);
		end else if (r < 65) begin
			// cut short inside a header or value
			add_elements($urandom_range(1, 3), 1'b0);
			keep = $urandom_range(1, frame_q.size() - 1);
			while (frame_q.size() > keep)
				void'(frame_q.pop_back());
		end else if (r < 72) begin
			add_elements($urandom_range(0, 2), 1'b0);
			add_word(pick_tag());
			add_word(32'h0);
			add_noise($urandom_range(0, 4));
		end else if (r < 79) begin
			add_elements($urandom_range(0, 2), 1'b0);
			add_word(pick_tag());
			if (cur_max == 32'hFFFF_FFFF) begin
				// accepted but far too long to finish, so it ends truncated
				add_word($urandom_range(32'h0001_0000, 32'hFFFF_FFFF));
				add_noise($urandom_range(1, 6));
			end else begin
				len = ($urandom_range(0, 1) == 0) ? cur_max + 32'd1 :
					$urandom_range(cur_max + 32'd1, 32'hFFFF_FFFF);
				add_word(len);
				add_noise($urandom_range(0, 4));
			end
		end else if (r < 86) begin
			add_elements($urandom_range(1, 3), 1'b0);
			add_word(used_tags[$urandom_range(0, used_tags.size() - 1)]);
			add_word(pick_len());
			add_noise($urandom_range(0, 3));
		end else if (r < 88) begin
			// table exactly full, or one element past it
			add_elements(MAX_EL + $urandom_range(0, 1), 1'b1);
		end else begin
			add_noise($urandom_range(1, 20));
		end
		send_frame();
	endtask

	initial begin
		int p;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_item    = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		bytes_sent = 0;
		hold_req   = 1'b0;
		tx_calm    = 1'b0;
		cur_max    = MAX_LEN_RESET;
		foreach (cur_tags[i])
			cur_tags[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Lone closing byte: truncated header
		frame_q.push_back(in_item_t'{data_byte: 8'hFF, buffer_end: 1'b0});
		send_frame();
		// One-byte value closed on its only byte: value and status together
		add_word(32'hFFFF_FFFF);
		add_word(32'd1);
		frame_q.push_back(in_item_t'{data_byte: 8'h00, buffer_end: 1'b0});
		send_frame();
		// Zero length, then a drained byte
		add_word(32'h0);
		add_word(32'h0);
		frame_q.push_back(in_item_t'{data_byte: 8'hA5, buffer_end: 1'b0});
		send_frame();
		// Length of all ones, closed on the header
		add_word(32'h1234_5678);
		add_word(32'hFFFF_FFFF);
		send_frame();
		settle();

		// Random buffers under several register settings
		for (p = 0; p < PHASES; p++) begin
			case (p)
				1: program_regs(32'd8, 3'd2, $urandom, $urandom, $urandom, $urandom);
				2: program_regs(32'hFFFF_FFFF, 3'd4, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom);
				3: program_regs(32'd1, 3'd7, $urandom, $urandom, $urandom, $urandom);
				4: program_regs(32'd0, 3'd5, $urandom, $urandom, $urandom, $urandom);
				5: program_regs(32'd3, 3'd3, $urandom, $urandom, $urandom, $urandom);
				default: ;
			endcase
			if (p == 1 || p == 3) begin
				add_elements(MAX_EL + 1, 1'b1);
				send_frame();
			end
			// long receiver hold-off while bytes keep coming
			if (p == 2 || p == 4)
				hold_req = 1'b1;
			while (bytes_sent < DIRECTED + (p + 1) * ((ITEM_BUDGET - DIRECTED) / PHASES))
				random_frame();
			settle();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
